### src/asa_pkg.sv
// ----------------------------------------------------------------------------
// asa_pkg
// Shared codes, counter indices and the event record passed from the record
// tally stage to the counter bank.
// ----------------------------------------------------------------------------
`default_nettype none

package asa_pkg;

	localparam logic [2:0] REQ_HEADER = 3'd0;
	localparam logic [2:0] REQ_OP     = 3'd1;
	localparam logic [2:0] REQ_QUAL   = 3'd2;
	localparam logic [2:0] REQ_MD     = 3'd3;
	localparam logic [2:0] REQ_END    = 3'd4;
	localparam logic [2:0] REQ_READ   = 3'd5;

	localparam logic [3:0] OP_M  = 4'd0;
	localparam logic [3:0] OP_I  = 4'd1;
	localparam logic [3:0] OP_D  = 4'd2;
	localparam logic [3:0] OP_S  = 4'd4;
	localparam logic [3:0] OP_EQ = 4'd7;
	localparam logic [3:0] OP_X  = 4'd8;

	localparam logic [1:0] CFG_FILTER_MASK = 2'd0;
	localparam logic [1:0] CFG_MAPQ_THR    = 2'd1;
	localparam logic [1:0] CFG_BASEQ_THR   = 2'd2;

	localparam int NUM_COUNTERS = 20;

	localparam int CNT_READS_TOTAL    = 0;
	localparam int CNT_BASES_TOTAL    = 1;
	localparam int CNT_READS_UNMAPPED = 2;
	localparam int CNT_BASES_UNMAPPED = 3;
	localparam int CNT_READS_MAPPED   = 4;
	localparam int CNT_BASES_MAPPED   = 5;
	localparam int CNT_READS_HIGH_MQ  = 6;
	localparam int CNT_READS_ALIGNED  = 7;
	localparam int CNT_READS_DUP      = 8;
	localparam int CNT_BASES_DUP      = 9;
	localparam int CNT_BASES_ALIGNED  = 10;
	localparam int CNT_BASES_MATCH    = 11;
	localparam int CNT_BASES_MISMATCH = 12;
	localparam int CNT_BASES_INS      = 13;
	localparam int CNT_BASES_DEL      = 14;
	localparam int CNT_READS_SCLIP    = 15;
	localparam int CNT_BASES_SCLIP    = 16;
	localparam int CNT_READS_EXACT    = 17;
	localparam int CNT_BASES_EXACT    = 18;
	localparam int CNT_BASES_HIGH_BQ  = 19;

	typedef struct packed {
		logic        hdr;
		logic        unmapped;
		logic        mapq_hi;
		logic        aln_read;
		logic        dup;
		logic [63:0] len;
		logic        qual_hi;
		logic        rec_end;
		logic        sclip_hit;
		logic        exact;
		logic [63:0] mism;
		logic [63:0] match;
		logic [63:0] aligned;
		logic [63:0] ins;
		logic [63:0] del;
		logic [63:0] sclip;
		logic        rd;
		logic [4:0]  idx;
	} evt_t;

endpackage

`default_nettype wire

### src/alignment_stats_accumulator.sv
// ----------------------------------------------------------------------------
// alignment_stats_accumulator
// Read and base statistics over a stream of aligned-read records.
//
// Items arrive on the s_axis channel; tuser carries the request kind and
// tdata the item fields. A record is a header, CIGAR ops with their quality
// bytes, MD characters and an end item. Only a counter read produces a
// transfer on m_axis, whose tdata is the 64-bit counter value.
// Throughput: one item per cycle unless m_axis stalls a read, set by the
// single pass through the record tally stage and the counter bank adders.
// Path: a counter read reaches m_axis through the input register, the
// counter stage and the output register.
// When m_axis stalls, the output register holds its result; items that
// produce no result keep flowing until a second read reaches the counter
// stage, then s_axis tready drops once the input register holds an item.
// Reset clears all counters and record state and loads the register
// defaults (filter mask 0x300, thresholds 20). Configuration writes on the
// cfg port take effect at the next clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

module alignment_stats_accumulator #(
	parameter int LENGTH_BITS = 28
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	// req_type[2:0]
	input  wire logic [7:0]    s_axis_tuser,
	// read_flags[15:0] mapping_quality[23:16] read_length[51:24]
	// process_detail[52] has_md[53] op_code[57:54] op_length[85:58]
	// base_quality[93:86] md_char[101:94] counter_index[106:102], zero fill
	input  wire logic [111:0]  s_axis_tdata,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// counter_value[63:0]
	output logic [63:0]        m_axis_tdata,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_addr,
	input  wire logic [15:0]   cfg_wdata
);
	import asa_pkg::*;

	logic [15:0]  filter_mask_q;
	logic [7:0]   mapq_thr_q;
	logic [7:0]   baseq_thr_q;

	logic         valid_s1;
	logic [2:0]   req_s1;
	logic [106:0] data_s1;
	logic         valid_s2;
	evt_t         evt_s2;
	evt_t         evt;
	logic [63:0]  rd_value;
	logic         adv_s1, adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mask_q <= 16'h0300;
			mapq_thr_q    <= 8'd20;
			baseq_thr_q   <= 8'd20;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_FILTER_MASK: filter_mask_q <= cfg_wdata;
				CFG_MAPQ_THR:    mapq_thr_q    <= cfg_wdata[7:0];
				CFG_BASEQ_THR:   baseq_thr_q   <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign adv_s2 = !(valid_s2 && evt_s2.rd && m_axis_tvalid && !m_axis_tready);
	assign adv_s1 = !valid_s2 || adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1  <= s_axis_tuser[2:0];
			data_s1 <= s_axis_tdata[106:0];
		end
	end

	asa_record #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_record (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.en                     (valid_s1 && adv_s1),
		.req_type               (req_s1),
		.read_flags             (data_s1[15:0]),
		.mapping_quality        (data_s1[23:16]),
		.read_length            (data_s1[51:24]),
		.process_detail         (data_s1[52]),
		.has_md                 (data_s1[53]),
		.op_code                (data_s1[57:54]),
		.op_length              (data_s1[85:58]),
		.base_quality           (data_s1[93:86]),
		.md_char                (data_s1[101:94]),
		.counter_index          (data_s1[106:102]),
		.filter_mask            (filter_mask_q),
		.mapq_threshold         (mapq_thr_q),
		.base_quality_threshold (baseq_thr_q),
		.evt                    (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			evt_s2 <= evt;
		end
	end

	asa_counters u_counters (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (valid_s2 && adv_s2),
		.evt      (evt_s2),
		.rd_value (rd_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (valid_s2 && adv_s2 && evt_s2.rd) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && adv_s2 && evt_s2.rd) begin
			m_axis_tdata <= rd_value;
		end
	end

endmodule

`default_nettype wire

### src/asa_record.sv
// ----------------------------------------------------------------------------
// asa_record
// Per-record tally: CIGAR sums, MD letters and derived differences kept
// incrementally, so that the end item needs only selects, compares and one subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module asa_record #(
	parameter int LENGTH_BITS = 28
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic [2:0]          req_type,
	input  wire logic [15:0]         read_flags,
	input  wire logic [7:0]          mapping_quality,
	input  wire logic [27:0]         read_length,
	input  wire logic                process_detail,
	input  wire logic                has_md,
	input  wire logic [3:0]          op_code,
	input  wire logic [27:0]         op_length,
	input  wire logic [7:0]          base_quality,
	input  wire logic [7:0]          md_char,
	input  wire logic [4:0]          counter_index,
	input  wire logic [15:0]         filter_mask,
	input  wire logic [7:0]          mapq_threshold,
	input  wire logic [7:0]          base_quality_threshold,
	output asa_pkg::evt_t            evt
);
	import asa_pkg::*;

	localparam int LEN_W = (LENGTH_BITS < 28) ? LENGTH_BITS : 28;

	logic        active_q;
	logic        has_md_q;
	logic [63:0] rec_len_q;
	logic [3:0]  cur_op_q;
	logic [63:0] sum_m_q, sum_i_q, sum_d_q, sum_s_q, sum_eq_q, sum_x_q;
	logic [63:0] mism_md_q, match_md_q, m_minus_x_q, exact_md_q, exact_nomd_q;

	logic [63:0] hdr_len, op_len;
	logic        is_letter, aligned_op;

	assign hdr_len = 64'(read_length[LEN_W-1:0]);
	assign op_len  = 64'(op_length[LEN_W-1:0]);

	assign is_letter = ((md_char >= 8'h41) && (md_char <= 8'h5A)) ||
		((md_char >= 8'h61) && (md_char <= 8'h7A));

	assign aligned_op = (cur_op_q == OP_M) || (cur_op_q == OP_I) ||
		(cur_op_q == OP_EQ) || (cur_op_q == OP_X);

	always_comb begin
		evt = '0;
		unique case (req_type)
			REQ_HEADER: begin
				evt.hdr      = 1'b1;
				evt.unmapped = read_flags[2];
				evt.mapq_hi  = mapping_quality >= mapq_threshold;
				evt.aln_read = (read_flags & filter_mask) == 16'd0;
				evt.dup      = read_flags[10];
				evt.len      = hdr_len;
			end
			REQ_QUAL: begin
				evt.qual_hi = active_q && aligned_op && (base_quality >= base_quality_threshold);
			end
			REQ_END: begin
				evt.rec_end   = active_q;
				evt.sclip_hit = sum_s_q != 64'd0;
				evt.mism      = has_md_q ? mism_md_q : sum_x_q;
				if (has_md_q) begin
					evt.match = match_md_q;
				end else begin
					evt.match = (sum_m_q > sum_eq_q) ? m_minus_x_q : sum_eq_q;
				end
				evt.aligned = (sum_s_q != 64'd0) ? rec_len_q - sum_s_q : rec_len_q;
				evt.ins     = sum_i_q;
				evt.del     = sum_d_q;
				evt.sclip   = sum_s_q;
				evt.exact   = (has_md_q ? exact_md_q : exact_nomd_q) == 64'd0;
			end
			REQ_READ: begin
				evt.rd  = 1'b1;
				evt.idx = counter_index;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			has_md_q     <= 1'b0;
			rec_len_q    <= '0;
			cur_op_q     <= '0;
			sum_m_q      <= '0;
			sum_i_q      <= '0;
			sum_d_q      <= '0;
			sum_s_q      <= '0;
			sum_eq_q     <= '0;
			sum_x_q      <= '0;
			mism_md_q    <= '0;
			match_md_q   <= '0;
			m_minus_x_q  <= '0;
			exact_md_q   <= '0;
			exact_nomd_q <= '0;
		end else if (en) begin
			if (req_type == REQ_HEADER) begin
				active_q     <= !read_flags[2] && process_detail;
				has_md_q     <= has_md;
				rec_len_q    <= hdr_len;
				sum_m_q      <= '0;
				sum_i_q      <= '0;
				sum_d_q      <= '0;
				sum_s_q      <= '0;
				sum_eq_q     <= '0;
				sum_x_q      <= '0;
				mism_md_q    <= '0;
				match_md_q   <= '0;
				m_minus_x_q  <= '0;
				exact_md_q   <= '0;
				exact_nomd_q <= '0;
			end else if (active_q) begin
				if (req_type == REQ_OP) begin
					cur_op_q <= op_code;
					case (op_code)
						OP_M: begin
							sum_m_q     <= sum_m_q + op_len;
							match_md_q  <= match_md_q + op_len;
							m_minus_x_q <= m_minus_x_q + op_len;
						end
						OP_I: begin
							sum_i_q      <= sum_i_q + op_len;
							exact_md_q   <= exact_md_q + op_len;
							exact_nomd_q <= exact_nomd_q + op_len;
						end
						OP_D: begin
							sum_d_q      <= sum_d_q + op_len;
							mism_md_q    <= mism_md_q - op_len;
							match_md_q   <= match_md_q + op_len;
							exact_nomd_q <= exact_nomd_q + op_len;
						end
						OP_S: begin
							sum_s_q <= sum_s_q + op_len;
						end
						OP_EQ: begin
							sum_eq_q <= sum_eq_q + op_len;
						end
						OP_X: begin
							sum_x_q      <= sum_x_q + op_len;
							m_minus_x_q  <= m_minus_x_q - op_len;
							exact_nomd_q <= exact_nomd_q + op_len;
						end
						default: begin
						end
					endcase
				end else if (req_type == REQ_MD) begin
					if (has_md_q && is_letter) begin
						mism_md_q  <= mism_md_q + 64'd1;
						match_md_q <= match_md_q - 64'd1;
						exact_md_q <= exact_md_q + 64'd1;
					end
				end else if (req_type == REQ_END) begin
					active_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

### src/asa_counters.sv
// ----------------------------------------------------------------------------
// asa_counters
// Bank of the twenty 64-bit statistics counters with one adder each and a
// read select for counter requests.
// ----------------------------------------------------------------------------
`default_nettype none

module asa_counters (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire asa_pkg::evt_t evt,
	output logic [63:0]        rd_value
);
	import asa_pkg::*;

	logic [63:0] cnt_q [NUM_COUNTERS];
	logic [63:0] inc   [NUM_COUNTERS];

	always_comb begin
		for (int i = 0; i < NUM_COUNTERS; i++) begin
			inc[i] = '0;
		end
		if (evt.hdr) begin
			inc[CNT_READS_TOTAL] = 64'd1;
			inc[CNT_BASES_TOTAL] = evt.len;
			if (evt.unmapped) begin
				inc[CNT_READS_UNMAPPED] = 64'd1;
				inc[CNT_BASES_UNMAPPED] = evt.len;
			end else begin
				inc[CNT_READS_MAPPED] = 64'd1;
				inc[CNT_BASES_MAPPED] = evt.len;
				if (evt.mapq_hi) begin
					inc[CNT_READS_HIGH_MQ] = 64'd1;
				end
				if (evt.aln_read) begin
					inc[CNT_READS_ALIGNED] = 64'd1;
				end
				if (evt.dup) begin
					inc[CNT_READS_DUP] = 64'd1;
					inc[CNT_BASES_DUP] = evt.len;
				end
			end
		end
		if (evt.qual_hi) begin
			inc[CNT_BASES_HIGH_BQ] = 64'd1;
		end
		if (evt.rec_end) begin
			inc[CNT_BASES_ALIGNED]  = evt.aligned;
			inc[CNT_BASES_MATCH]    = evt.match;
			inc[CNT_BASES_MISMATCH] = evt.mism;
			inc[CNT_BASES_INS]      = evt.ins;
			inc[CNT_BASES_DEL]      = evt.del;
			if (evt.sclip_hit) begin
				inc[CNT_READS_SCLIP] = 64'd1;
				inc[CNT_BASES_SCLIP] = evt.sclip;
			end
			if (evt.exact) begin
				inc[CNT_READS_EXACT] = 64'd1;
				inc[CNT_BASES_EXACT] = evt.aligned;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COUNTERS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (en) begin
			for (int i = 0; i < NUM_COUNTERS; i++) begin
				cnt_q[i] <= cnt_q[i] + inc[i];
			end
		end
	end

	assign rd_value = (evt.idx < 5'(NUM_COUNTERS)) ? cnt_q[evt.idx] : 64'd0;

endmodule

`default_nettype wire
